// ===== hw/rtl/gauss_seidel_grid_relaxation_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grid relaxation block
// Clocked, reset-qualified property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef GAUSS_SEIDEL_GRID_RELAXATION_ASSERT_SVH
`define GAUSS_SEIDEL_GRID_RELAXATION_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define GSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gsr_pkg.sv =====
// ----------------------------------------------------------------------------
// gsr_pkg
// Shared constants and types of the grid relaxation block.
// ----------------------------------------------------------------------------
`default_nettype none

package gsr_pkg;

    localparam logic [5:0] MAX_INTERIOR = 6'd62;
    localparam logic [4:0] SWEEPS = 5'd20;
    localparam int ADDR_W = 12;
    localparam logic [30:0] C_MIN = 31'd65536;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] CFG_SIZE = 2'd0;
    localparam logic [1:0] CFG_MODE = 2'd1;
    localparam logic [1:0] CFG_A = 2'd2;
    localparam logic [1:0] CFG_C = 2'd3;

    localparam logic [1:0] MODE_NEG_LR = 2'd1;
    localparam logic [1:0] MODE_NEG_TB = 2'd2;

    typedef struct packed {
        logic               start;
        logic signed [33:0] sum;
        logic signed [31:0] rhs;
        logic [30:0]        coef_a;
        logic [30:0]        coef_c;
    } t_relax_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } t_relax_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/gsr_store.sv =====
// ----------------------------------------------------------------------------
// gsr_store
// Solution and right-hand-side memories, one write and one registered read each.
// ----------------------------------------------------------------------------
`default_nettype none

module gsr_store (
    input  wire logic                         i_clk,
    input  wire logic                         i_sol_we,
    input  wire logic [gsr_pkg::ADDR_W-1:0]   i_sol_waddr,
    input  wire logic [31:0]                  i_sol_wdata,
    input  wire logic [gsr_pkg::ADDR_W-1:0]   i_sol_raddr,
    output logic [31:0]                       o_sol_rdata,
    input  wire logic                         i_rhs_we,
    input  wire logic [gsr_pkg::ADDR_W-1:0]   i_rhs_waddr,
    input  wire logic [31:0]                  i_rhs_wdata,
    input  wire logic [gsr_pkg::ADDR_W-1:0]   i_rhs_raddr,
    output logic [31:0]                       o_rhs_rdata
);

    logic [31:0] r_sol_mem [2**gsr_pkg::ADDR_W];
    logic [31:0] r_rhs_mem [2**gsr_pkg::ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_sol_we) begin
            r_sol_mem[i_sol_waddr] <= i_sol_wdata;
        end
        o_sol_rdata <= r_sol_mem[i_sol_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_rhs_we) begin
            r_rhs_mem[i_rhs_waddr] <= i_rhs_wdata;
        end
        o_rhs_rdata <= r_rhs_mem[i_rhs_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gsr_relax_unit.sv =====
// ----------------------------------------------------------------------------
// gsr_relax_unit
// Multi-cycle arithmetic of one cell update: scaled neighbor sum plus rhs,
// divided by the center divisor with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module gsr_relax_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gsr_pkg::t_relax_req i_req,
    output gsr_pkg::t_relax_rsp      o_rsp
);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_MLO  = 3'd1;
    localparam logic [2:0] U_MHI  = 3'd2;
    localparam logic [2:0] U_NUM  = 3'd3;
    localparam logic [2:0] U_PRE  = 3'd4;
    localparam logic [2:0] U_DIV  = 3'd5;
    localparam logic [2:0] U_FIN  = 3'd6;

    localparam logic signed [50:0] NUM_MAX = 51'sd70368744177664;
    localparam logic signed [50:0] NUM_MIN = -51'sd70368744177664;

    logic [2:0]         r_state;
    logic [5:0]         r_cnt;
    logic [33:0]        r_mag;
    logic               r_sneg;
    logic signed [31:0] r_rhs;
    logic [30:0]        r_a;
    logic [30:0]        r_c;
    logic [64:0]        r_prod;
    logic               r_nneg;
    logic [46:0]        r_nmag;
    logic               r_sat;
    logic [30:0]        r_rem;
    logic [32:0]        r_dsh;
    logic [32:0]        r_q;
    logic               r_done;
    logic signed [31:0] r_value;

    logic [16:0]        w_mop;
    logic [47:0]        w_mul;
    logic signed [50:0] w_p;
    logic signed [50:0] w_n;
    logic [31:0]        w_trial;
    logic               w_ge;

    assign w_mop = (r_state == U_MLO) ? r_mag[16:0] : r_mag[33:17];
    assign w_mul = 48'(r_a) * 48'(w_mop);
    assign w_trial = {r_rem, r_dsh[32]};
    assign w_ge = (w_trial >= 32'(r_c));

    always_comb begin
        w_p = $signed({2'b00, r_prod[64:16]});
        w_n = 51'(r_rhs) + (r_sneg ? -w_p : w_p);
        if (w_n > NUM_MAX) begin
            w_n = NUM_MAX;
        end else if (w_n < NUM_MIN) begin
            w_n = NUM_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_state <= U_MLO;
                    end
                end
                U_MLO: r_state <= U_MHI;
                U_MHI: r_state <= U_NUM;
                U_NUM: r_state <= U_PRE;
                U_PRE: begin
                    r_state <= ({1'b0, r_nmag[46:17]} >= r_c) ? U_FIN : U_DIV;
                end
                U_DIV: begin
                    if (r_cnt == 6'd1) begin
                        r_state <= U_FIN;
                    end
                end
                U_FIN: begin
                    r_state <= U_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                r_sneg <= i_req.sum[33];
                r_mag  <= i_req.sum[33] ? 34'(-i_req.sum) : 34'(i_req.sum);
                r_rhs  <= i_req.rhs;
                r_a    <= i_req.coef_a;
                r_c    <= i_req.coef_c;
            end
            U_MLO: r_prod <= 65'(w_mul);
            U_MHI: r_prod <= r_prod + {w_mul, 17'b0};
            U_NUM: begin
                r_nneg <= w_n[50];
                r_nmag <= w_n[50] ? 47'(-w_n) : 47'(w_n);
            end
            U_PRE: begin
                r_sat <= ({1'b0, r_nmag[46:17]} >= r_c);
                r_rem <= 31'(r_nmag[46:17]);
                r_dsh <= {r_nmag[16:0], 16'b0};
                r_q   <= '0;
                r_cnt <= 6'd33;
            end
            U_DIV: begin
                r_rem <= w_ge ? 31'(w_trial - 32'(r_c)) : 31'(w_trial);
                r_dsh <= {r_dsh[31:0], 1'b0};
                r_q   <= {r_q[31:0], w_ge};
                r_cnt <= r_cnt - 6'd1;
            end
            U_FIN: begin
                if (r_sat) begin
                    r_value <= r_nneg ? 32'sh80000000 : 32'sh7fffffff;
                end else if (!r_nneg) begin
                    r_value <= (r_q > 33'h07fffffff) ? 32'sh7fffffff : $signed(r_q[31:0]);
                end else begin
                    r_value <= (r_q > 33'h080000000) ? 32'sh80000000 : $signed(32'(-r_q));
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

`default_nettype wire

// ===== hw/rtl/gauss_seidel_grid_relaxation.sv =====
// ----------------------------------------------------------------------------
// gauss_seidel_grid_relaxation
// Gauss-Seidel relaxation over a square grid held in on-chip memory.
// ----------------------------------------------------------------------------
// A load item writes one cell of the solution and rhs memories, and a read
// item returns the cell value via the capture state and the output register.
// A solve item runs 20 sweeps through the single read port of the solution
// memory: each interior cell takes five reads plus the arithmetic unit, whose
// 33-step divider dominates, and each sweep then copies edges and sets the
// four corners. The block takes no new item until the solve is done.
`default_nettype none

module gauss_seidel_grid_relaxation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_in_operation,
    input  wire logic [11:0] i_in_cell_index,
    input  wire logic signed [31:0] i_in_guess_value,
    input  wire logic signed [31:0] i_in_rhs_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [31:0] o_out_cell_value,
    output logic             o_out_solve_done
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDOUT  = 3'd1;
    localparam logic [2:0] ST_C_RD   = 3'd2;
    localparam logic [2:0] ST_C_CALC = 3'd3;
    localparam logic [2:0] ST_EDGE   = 3'd4;
    localparam logic [2:0] ST_CORNER = 3'd5;

    function automatic logic [31:0] neg_sat(input logic [31:0] v);
        return (v == 32'h80000000) ? 32'h7fffffff : 32'(-v);
    endfunction

    function automatic logic [31:0] halve(input logic [31:0] u, input logic [31:0] v);
        logic signed [32:0] s;
        s = $signed({u[31], u}) + $signed({v[31], v});
        if (s[32]) begin
            s = s + 33'sd1;
        end
        return 32'(s >>> 1);
    endfunction

    logic [5:0]  r_size;
    logic [1:0]  r_mode;
    logic [30:0] r_coef_a;
    logic [30:0] r_coef_c;

    logic [2:0]  r_state;
    logic [4:0]  r_sweep;
    logic [5:0]  r_x;
    logic [5:0]  r_y;
    logic [2:0]  r_k;
    logic [1:0]  r_corner;
    logic signed [33:0] r_sum;
    logic [31:0] r_tmp;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic        r_out_done;

    logic [5:0]  w_n;
    logic [6:0]  w_s;
    logic [12:0] w_sx;
    logic [12:0] w_sy;
    logic [12:0] w_sn;
    logic [12:0] w_sn1;
    logic [11:0] w_idx;
    logic [11:0] w_raddr;
    logic [11:0] w_edge_dst;
    logic [11:0] w_cor_a;
    logic [11:0] w_cor_b;
    logic [11:0] w_cor_d;
    logic        w_sol_we;
    logic [11:0] w_sol_waddr;
    logic [31:0] w_sol_wdata;
    logic [31:0] w_sol_rdata;
    logic [31:0] w_rhs_rdata;
    logic        w_in_acc;
    logic        w_load;
    logic        w_edge_neg;
    logic signed [33:0] w_sum_next;
    gsr_pkg::t_relax_req w_req;
    gsr_pkg::t_relax_rsp w_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= gsr_pkg::MAX_INTERIOR;
            r_mode   <= 2'd0;
            r_coef_a <= 31'd65536;
            r_coef_c <= 31'd262144;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gsr_pkg::CFG_SIZE: r_size <= i_cfg_data[5:0];
                gsr_pkg::CFG_MODE: r_mode <= i_cfg_data[1:0];
                gsr_pkg::CFG_A:    r_coef_a <= i_cfg_data;
                gsr_pkg::CFG_C:    r_coef_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_n = r_size;
        if (w_n == 6'd0) begin
            w_n = 6'd1;
        end else if (w_n > gsr_pkg::MAX_INTERIOR) begin
            w_n = gsr_pkg::MAX_INTERIOR;
        end
    end

    assign w_s   = 7'(w_n) + 7'd2;
    assign w_sx  = 13'(w_s) * 13'(r_x);
    assign w_sy  = 13'(w_s) * 13'(r_y);
    assign w_sn  = 13'(w_s) * 13'(w_n);
    assign w_sn1 = 13'(w_s) * (13'(w_n) + 13'd1);
    assign w_idx = 12'(13'(r_x) + w_sy);

    always_comb begin
        unique case (r_corner)
            2'd0: begin
                w_cor_a = 12'd1;
                w_cor_b = 12'(w_s);
                w_cor_d = 12'd0;
            end
            2'd1: begin
                w_cor_a = 12'(13'd1 + w_sn1);
                w_cor_b = 12'(w_sn);
                w_cor_d = 12'(w_sn1);
            end
            2'd2: begin
                w_cor_a = 12'(w_n);
                w_cor_b = 12'(13'(w_n) + 13'd1 + 13'(w_s));
                w_cor_d = 12'(w_n) + 12'd1;
            end
            default: begin
                w_cor_a = 12'(13'(w_n) + w_sn1);
                w_cor_b = 12'(13'(w_n) + 13'd1 + w_sn);
                w_cor_d = 12'(13'(w_n) + 13'd1 + w_sn1);
            end
        endcase
    end

    always_comb begin
        w_raddr = w_idx;
        case (r_state)
            ST_IDLE: w_raddr = i_in_cell_index;
            ST_C_RD: begin
                case (r_k)
                    3'd0: w_raddr = w_idx - 12'd1;
                    3'd1: w_raddr = w_idx + 12'd1;
                    3'd2: w_raddr = w_idx - 12'(w_s);
                    default: w_raddr = w_idx + 12'(w_s);
                endcase
            end
            ST_EDGE: begin
                case (r_k)
                    3'd0: w_raddr = 12'(13'd1 + w_sx);
                    3'd1: w_raddr = 12'(13'(w_n) + w_sx);
                    3'd2: w_raddr = 12'(13'(r_x) + 13'(w_s));
                    default: w_raddr = 12'(13'(r_x) + w_sn);
                endcase
            end
            ST_CORNER: w_raddr = (r_k == 3'd0) ? w_cor_a : w_cor_b;
            default: ;
        endcase
    end

    always_comb begin
        case (r_k)
            3'd1: w_edge_dst = 12'(w_sx);
            3'd2: w_edge_dst = 12'(13'(w_n) + 13'd1 + w_sx);
            3'd3: w_edge_dst = 12'(r_x);
            default: w_edge_dst = 12'(13'(r_x) + w_sn1);
        endcase
    end

    assign w_edge_neg = (r_k <= 3'd2) ? (r_mode == gsr_pkg::MODE_NEG_LR)
                                      : (r_mode == gsr_pkg::MODE_NEG_TB);

    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_load     = w_in_acc && (i_in_operation == gsr_pkg::OP_LOAD);

    always_comb begin
        w_sol_we    = 1'b0;
        w_sol_waddr = i_in_cell_index;
        w_sol_wdata = i_in_guess_value;
        case (r_state)
            ST_IDLE: w_sol_we = w_load;
            ST_C_CALC: begin
                w_sol_we    = w_rsp.done;
                w_sol_waddr = w_idx;
                w_sol_wdata = w_rsp.value;
            end
            ST_EDGE: begin
                w_sol_we    = (r_k != 3'd0);
                w_sol_waddr = w_edge_dst;
                w_sol_wdata = w_edge_neg ? neg_sat(w_sol_rdata) : w_sol_rdata;
            end
            ST_CORNER: begin
                w_sol_we    = (r_k == 3'd2);
                w_sol_waddr = w_cor_d;
                w_sol_wdata = halve(r_tmp, w_sol_rdata);
            end
            default: ;
        endcase
    end

    assign w_sum_next = r_sum + 34'($signed(w_sol_rdata));

    assign w_req.start  = (r_state == ST_C_RD) && (r_k == 3'd4);
    assign w_req.sum    = w_sum_next;
    assign w_req.rhs    = w_rhs_rdata;
    assign w_req.coef_a = r_coef_a;
    assign w_req.coef_c = (r_coef_c < gsr_pkg::C_MIN) ? gsr_pkg::C_MIN : r_coef_c;

    gsr_store u_store (
        .i_clk       (i_clk),
        .i_sol_we    (w_sol_we),
        .i_sol_waddr (w_sol_waddr),
        .i_sol_wdata (w_sol_wdata),
        .i_sol_raddr (w_raddr),
        .o_sol_rdata (w_sol_rdata),
        .i_rhs_we    (w_load),
        .i_rhs_waddr (i_in_cell_index),
        .i_rhs_wdata (i_in_rhs_value),
        .i_rhs_raddr (w_idx),
        .o_rhs_rdata (w_rhs_rdata)
    );

    gsr_relax_unit u_relax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sweep     <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_k         <= '0;
            r_corner    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && i_in_operation == gsr_pkg::OP_READ) begin
                        r_state <= ST_RDOUT;
                    end else if (w_in_acc && i_in_operation == gsr_pkg::OP_SOLVE) begin
                        r_state <= ST_C_RD;
                        r_sweep <= '0;
                        r_x     <= 6'd1;
                        r_y     <= 6'd1;
                        r_k     <= '0;
                    end
                end
                ST_RDOUT: begin
                    r_state     <= ST_IDLE;
                    r_out_valid <= 1'b1;
                    r_out_value <= w_sol_rdata;
                    r_out_done  <= 1'b0;
                end
                ST_C_RD: begin
                    r_sum <= (r_k == 3'd0) ? 34'sd0 : w_sum_next;
                    if (r_k == 3'd4) begin
                        r_state <= ST_C_CALC;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                ST_C_CALC: begin
                    if (w_rsp.done) begin
                        r_k <= '0;
                        if (r_y == w_n) begin
                            r_y <= 6'd1;
                            if (r_x == w_n) begin
                                r_x     <= 6'd1;
                                r_state <= ST_EDGE;
                            end else begin
                                r_x     <= r_x + 6'd1;
                                r_state <= ST_C_RD;
                            end
                        end else begin
                            r_y     <= r_y + 6'd1;
                            r_state <= ST_C_RD;
                        end
                    end
                end
                ST_EDGE: begin
                    if (r_k == 3'd4) begin
                        r_k <= '0;
                        if (r_x == w_n) begin
                            r_x      <= 6'd1;
                            r_corner <= '0;
                            r_state  <= ST_CORNER;
                        end else begin
                            r_x <= r_x + 6'd1;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                ST_CORNER: begin
                    if (r_k == 3'd1) begin
                        r_tmp <= w_sol_rdata;
                    end
                    if (r_k == 3'd2) begin
                        r_k <= '0;
                        if (r_corner == 2'd3) begin
                            r_corner <= '0;
                            if (r_sweep == gsr_pkg::SWEEPS - 5'd1) begin
                                r_sweep     <= '0;
                                r_x         <= '0;
                                r_y         <= '0;
                                r_state     <= ST_IDLE;
                                r_out_valid <= 1'b1;
                                r_out_value <= '0;
                                r_out_done  <= 1'b1;
                            end else begin
                                r_sweep <= r_sweep + 5'd1;
                                r_y     <= 6'd1;
                                r_state <= ST_C_RD;
                            end
                        end else begin
                            r_corner <= r_corner + 2'd1;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_cell_value = r_out_value;
    assign o_out_solve_done = r_out_done;

`include "gauss_seidel_grid_relaxation_assert.svh"

    `GSR_ASSERT_NOW(a_solve_result_zero, o_out_valid && o_out_solve_done,
        o_out_cell_value == 32'sd0, "solve result carries a nonzero value")
    `GSR_ASSERT_NOW(a_sweep_bound, 1'b1, r_sweep < gsr_pkg::SWEEPS,
        "sweep counter out of range")
    `GSR_ASSERT_NOW(a_done_in_calc, w_rsp.done, r_state == ST_C_CALC,
        "cell result arrived outside the calculation state")
    `GSR_ASSERT_NEXT(a_read_capture,
        w_in_acc && i_in_operation == gsr_pkg::OP_READ, r_state == ST_RDOUT,
        "accepted read did not move to the capture state")

endmodule

`default_nettype wire
